FILE: rtl/abe_pkg.sv
// shared constants, types and helpers of the allocation bitmap engine
package abe_pkg;

  localparam int MAX_BYTES   = 64;
  localparam int POS_BYTES   = 64;
  localparam int STORE_BYTES = (MAX_BYTES < POS_BYTES) ? MAX_BYTES : POS_BYTES;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int CFG_W       = 7;
  localparam int POS_W       = 9;

  localparam logic [CFG_W-1:0] CFG_RESET     = 7'd64;
  localparam logic [CFG_W-1:0] STORE_BYTES_C = CFG_W'(STORE_BYTES);

  localparam logic [1:0] OP_FIND  = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_TEST  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  localparam logic REG_BYTES_IN_USE = 1'b0;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] bit_idx;
  } first_hit_t;

  // lowest set bit of a byte
  function automatic first_hit_t first_set(input logic [7:0] v);
    first_hit_t r;
    r.hit     = 1'b0;
    r.bit_idx = 3'd0;
    for (int j = 7; j >= 0; j--) begin
      if (v[j]) begin
        r.hit     = 1'b1;
        r.bit_idx = 3'(j);
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/abe_bitmap_ram.sv
// bitmap byte store with registered read and per-byte valid flags
module abe_bitmap_ram
  import abe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ram_req_t   req_i,
  output logic [7:0] rd_data_o
);

  logic [7:0]             mem [STORE_BYTES];
  logic [STORE_BYTES-1:0] valid_q;
  logic [7:0]             rd_data_q;
  logic                   rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rd_data_q <= mem[req_i.raddr];
  end

  // unwritten bytes read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      rd_valid_q <= valid_q[req_i.raddr];
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : 8'd0;

endmodule

FILE: rtl/abe_cfg_regs.sv
// apb register file holding the bytes-in-use setting
module abe_cfg_regs
  import abe_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [CFG_W-1:0] bytes_in_use_o
);

  logic [CFG_W-1:0] bytes_in_use_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_BYTES_IN_USE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_in_use_q <= CFG_RESET;
    end else if (wr_en) begin
      bytes_in_use_q <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_BYTES_IN_USE) begin
      prdata = {{(32-CFG_W){1'b0}}, bytes_in_use_q};
    end
  end

  assign bytes_in_use_o = bytes_in_use_q;

endmodule

FILE: rtl/allocation_bitmap_engine_top.sv
// allocation bitmap engine: control sequencer, byte store and register port
//
// Bitmap allocator over up to 64 bytes (512 positions, LSB-first within each
// byte), all clear after reset. A request is taken only when the sequencer
// is idle; its result sits in an output register, so the next request may be
// taken while that result still waits for its transfer. Set, clear and test
// pass through accept with read issue, read data with write-back and result
// load, which waits until the output register is free. Find-first scans at
// most the bytes in use, capped at 64, one byte per cycle: the store has one
// read port, and the read of the next byte is issued as the current one comes
// back. With no bytes in use or an out-of-range position the sequencer skips
// the read and goes straight to the result load.
// Writes to bytes_in_use are meant to happen only while the engine is idle.
module allocation_bitmap_engine_top
  import abe_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // request channel
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       opcode_i,
  input  logic [POS_W-1:0] position_i,
  input  logic             search_value_i,
  // result channel
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       status_o,
  output logic [POS_W-1:0] found_position_o,
  output logic             tested_bit_o,
  // configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [1:0]        op_q;
  logic              want_q;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic [2:0]        bit_q;
  logic [1:0]        res_status_q, res_status_d;
  logic [POS_W-1:0]  res_found_q, res_found_d;
  logic              res_bit_q, res_bit_d;

  logic              out_valid_q;
  logic [1:0]        out_status_q;
  logic [POS_W-1:0]  out_found_q;
  logic              out_bit_q;

  logic [CFG_W-1:0]  bytes_in_use;
  logic [CFG_W-1:0]  eff_bytes;
  logic              in_xfer;
  logic              out_free;
  logic              in_range;
  logic [ADDR_W-1:0] pos_byte;
  logic [7:0]        rd_data;
  logic [7:0]        match_vec;
  first_hit_t        hit;
  logic              last_byte;
  ram_req_t          ram_req;

  abe_cfg_regs u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .bytes_in_use_o (bytes_in_use)
  );

  abe_bitmap_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ram_req),
    .rd_data_o (rd_data)
  );

  // bytes actually searched, saturated to the store depth
  assign eff_bytes = (bytes_in_use > STORE_BYTES_C) ? STORE_BYTES_C : bytes_in_use;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // position limit is eight times the bytes in use
  assign in_range = {1'b0, position_i} < {eff_bytes, 3'b000};
  assign pos_byte = position_i[3 +: ADDR_W];

  // bits of the returning byte that equal the searched value
  assign match_vec = want_q ? rd_data : ~rd_data;
  assign hit       = first_set(match_vec);
  assign last_byte = (CFG_W'(idx_q) + CFG_W'(1)) == eff_bytes;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_bit_d    = res_bit_q;
    ram_req      = '0;

    case (state_q)
      S_IDLE: begin
        if (opcode_i == OP_FIND) begin
          ram_req.raddr = '0;
        end else begin
          ram_req.raddr = pos_byte;
        end
        if (in_xfer) begin
          res_status_d = ST_OK;
          res_found_d  = '0;
          res_bit_d    = 1'b0;
          idx_d        = '0;
          if (opcode_i == OP_FIND) begin
            if (eff_bytes == '0) begin
              res_status_d = ST_NOT_FOUND;
              state_d      = S_DONE;
            end else begin
              state_d = S_READ;
            end
          end else if (!in_range) begin
            res_status_d = ST_RANGE;
            state_d      = S_DONE;
          end else begin
            idx_d   = pos_byte;
            state_d = S_READ;
          end
        end
      end

      S_READ: begin
        if (op_q == OP_FIND) begin
          // prefetch the next byte while this one is checked
          ram_req.raddr = idx_q + ADDR_W'(1);
          if (hit.hit) begin
            res_found_d = POS_W'({idx_q, hit.bit_idx});
            state_d     = S_DONE;
          end else if (last_byte) begin
            res_status_d = ST_NOT_FOUND;
            state_d      = S_DONE;
          end else begin
            idx_d = idx_q + ADDR_W'(1);
          end
        end else begin
          ram_req.raddr = idx_q;
          ram_req.waddr = idx_q;
          case (op_q)
            OP_SET: begin
              ram_req.we    = 1'b1;
              ram_req.wdata = rd_data | (8'd1 << bit_q);
            end
            OP_CLEAR: begin
              ram_req.we    = 1'b1;
              ram_req.wdata = rd_data & ~(8'd1 << bit_q);
            end
            default: begin
              res_bit_d = rd_data[bit_q];
            end
          endcase
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        ram_req.raddr = idx_q;
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q   <= opcode_i;
      want_q <= search_value_i;
      bit_q  <= position_i[2:0];
    end
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_bit_q    <= res_bit_d;
    if (state_q == S_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_bit_q    <= res_bit_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign found_position_o = out_found_q;
  assign tested_bit_o     = out_bit_q;

endmodule

FILE: tb/sv/tb_top.sv
// self-checking testbench of the allocation bitmap engine
`timescale 1ns / 1ps

module tb_top;
  import abe_pkg::*;

  // cycles with no transfer on either channel before the run is abandoned
  localparam int WATCHDOG_LIMIT = 4000;
  // longest find-first scan plus some margin, waited out before the end
  localparam int SETTLE_CYCLES = STORE_BYTES + 8;
  // byte addresses on the register port
  localparam logic [2:0] ADDR_BYTES_IN_USE = 3'd0;
  localparam logic [2:0] ADDR_SPARE        = 3'd4;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] found_position;
    logic             tested_bit;
  } alloc_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready_o;
  logic [1:0]       opcode = OP_FIND;
  logic [POS_W-1:0] position = '0;
  logic             search_value = 1'b0;
  logic             out_valid_o;
  logic             out_ready = 1'b0;
  logic [1:0]       status_o;
  logic [POS_W-1:0] found_position_o;
  logic             tested_bit_o;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [2:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  // shadow copy of the bitmap and of the size register
  logic [8*STORE_BYTES-1:0] shadow_map = '0;
  logic [CFG_W-1:0]         shadow_bytes = CFG_RESET;
  alloc_result_t            pending_results[$];
  alloc_result_t            oldest_result;
  int                       error_count = 0;
  int                       quiet_cycles = 0;
  // percentages of idle cycles on the request side and stalls on the result side
  int                       idle_pct = 0;
  int                       stall_pct = 0;

  allocation_bitmap_engine_top dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode),
    .position_i       (position),
    .search_value_i   (search_value),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .status_o         (status_o),
    .found_position_o (found_position_o),
    .tested_bit_o     (tested_bit_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // number of bit positions in use: the engine saturates the size at the store size
  function automatic int live_bits();
    return ((shadow_bytes > STORE_BYTES_C) ? STORE_BYTES : int'(shadow_bytes)) * 8;
  endfunction

  // works out the result of one request and updates the shadow bitmap
  function automatic alloc_result_t apply_request(input logic [1:0] op,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic want);
    alloc_result_t r;
    int limit;
    r = '0;
    limit = live_bits();
    if (op == OP_FIND) begin
      r.status = ST_NOT_FOUND;
      // scan downwards so the lowest matching position is the one kept
      for (int p = limit - 1; p >= 0; p--) begin
        if (shadow_map[p] == want) begin
          r.status = ST_OK;
          r.found_position = POS_W'(p);
        end
      end
    end else if (int'(pos) >= limit) begin
      // out of range: bitmap untouched, other fields stay zero
      r.status = ST_RANGE;
    end else begin
      case (op)
        OP_SET:   shadow_map[pos] = 1'b1;
        OP_CLEAR: shadow_map[pos] = 1'b0;
        default:  r.tested_bit = shadow_map[pos];
      endcase
    end
    return r;
  endfunction

  // receiver: stalls at random according to the current phase
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // result checker: every result transfer is matched against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid_o && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing pending: status %0d position %0d bit %0d",
               status_o, found_position_o, tested_bit_o);
        error_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (status_o !== oldest_result.status) begin
          $error("status mismatch: expected %0d, got %0d", oldest_result.status, status_o);
          error_count++;
        end
        if (found_position_o !== oldest_result.found_position) begin
          $error("found_position mismatch: expected %0d, got %0d",
                 oldest_result.found_position, found_position_o);
          error_count++;
        end
        if (tested_bit_o !== oldest_result.tested_bit) begin
          $error("tested_bit mismatch: expected %0d, got %0d",
                 oldest_result.tested_bit, tested_bit_o);
          error_count++;
        end
      end
    end
  end

  // watchdog: ends the run once nothing has moved for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // presents one request, holds it until its transfer, then records the prediction;
  // valid is left high so back-to-back requests need no gap
  task automatic send_request(input logic [1:0] op, input logic [POS_W-1:0] pos,
                              input logic want);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    position     <= pos;
    search_value <= want;
    do @(posedge clk); while (!in_ready_o);
    pending_results.push_back(apply_request(op, pos, want));
  endtask

  // stops issuing and waits until every pending result has been taken
  task automatic wait_idle(input int extra);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // register write while the engine is idle, then read back of bytes_in_use
  task automatic program_register(input logic [2:0] addr, input logic [31:0] value);
    wait_idle(4);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // writes to the spare address are dropped
    if (addr == ADDR_BYTES_IN_USE) shadow_bytes = value[CFG_W-1:0];
    @(posedge clk);
    psel  <= 1'b1;
    paddr <= ADDR_BYTES_IN_USE;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== 32'(shadow_bytes)) begin
      $error("prdata mismatch: expected %0d, got %0d", shadow_bytes, prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // all four operations at the reset size, extremes of position
  task automatic test_basic_ops();
    send_request(OP_FIND, 9'd0, 1'b0);
    send_request(OP_FIND, 9'd511, 1'b1);
    send_request(OP_TEST, 9'd511, 1'b0);
    send_request(OP_SET, 9'd511, 1'b1);
    send_request(OP_TEST, 9'd511, 1'b1);
    send_request(OP_FIND, 9'd0, 1'b1);
    send_request(OP_SET, 9'd0, 1'b0);
    send_request(OP_FIND, 9'd511, 1'b1);
    send_request(OP_CLEAR, 9'd0, 1'b1);
    send_request(OP_CLEAR, 9'd511, 1'b0);
    send_request(OP_FIND, 9'd0, 1'b1);
    send_request(OP_SET, 9'd9, 1'b0);
    send_request(OP_FIND, 9'd511, 1'b0);
  endtask

  // a single byte in use: positions from 8 upwards are out of range
  task automatic test_narrow_bitmap();
    program_register(ADDR_BYTES_IN_USE, 32'd1);
    send_request(OP_SET, 9'd7, 1'b0);
    send_request(OP_FIND, 9'd0, 1'b1);
    send_request(OP_TEST, 9'd7, 1'b0);
    send_request(OP_SET, 9'd8, 1'b0);
    send_request(OP_CLEAR, 9'd8, 1'b1);
  endtask

  // no bytes in use: nothing found, every single-bit access out of range
  task automatic test_empty_bitmap();
    program_register(ADDR_BYTES_IN_USE, 32'd0);
    send_request(OP_FIND, 9'd0, 1'b0);
    send_request(OP_SET, 9'd0, 1'b1);
    send_request(OP_TEST, 9'd0, 1'b0);
  endtask

  // size beyond the store saturates to the full 512 positions
  task automatic test_saturated_size();
    program_register(ADDR_BYTES_IN_USE, 32'd127);
    send_request(OP_TEST, 9'd511, 1'b0);
    send_request(OP_FIND, 9'd0, 1'b1);
  endtask

  // a write to the spare address must leave the size alone
  task automatic test_unused_register();
    program_register(ADDR_SPARE, 32'hFFFF_FF81);
    send_request(OP_TEST, 9'd511, 1'b1);
  endtask

  // random traffic over several sizes and idling phases
  task automatic test_random_traffic();
    logic [6:0]       plan[8];
    logic [1:0]       op;
    logic [POS_W-1:0] pos;
    int               limit;
    int               pick;
    plan = '{7'd64, 7'd127, 7'd1, 7'd40, 7'd0, 7'd64, 7'd9, 7'd100};
    for (int blk = 0; blk < 8; blk++) begin
      case (blk / 2)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 65;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 65;
        end
        default: begin
          idle_pct  = 31;
          stall_pct = 31;
        end
      endcase
      program_register(ADDR_BYTES_IN_USE,
                       (blk == 7) ? 32'($urandom_range(127)) : 32'(plan[blk]));
      limit = live_bits();
      repeat (125) begin
        pick = $urandom_range(99);
        op = (pick < 30) ? OP_FIND : (pick < 62) ? OP_SET : (pick < 77) ? OP_CLEAR : OP_TEST;
        pick = $urandom_range(99);
        // mostly in range and clustered low so the searches meet a filling map
        if (limit > 0 && pick < 45) begin
          pos = POS_W'($urandom_range(((limit < 48) ? limit : 48) - 1));
        end else if (limit > 0 && pick < 80) begin
          pos = POS_W'($urandom_range(limit - 1));
        end else begin
          pos = POS_W'($urandom_range(511));
        end
        send_request(op, pos, 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_ops();
    test_narrow_bitmap();
    test_empty_bitmap();
    test_saturated_size();
    test_unused_register();
    test_random_traffic();
    // drain, then watch a while longer for stray results
    wait_idle(SETTLE_CYCLES);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
